FILE: src/velocity_key_scanner_assert.svh
// ----------------------------------------------------------------------------
// Velocity key scanner assertion macros
// Concurrent checks on a clock, with reset holding them off.
// ----------------------------------------------------------------------------
`ifndef VELOCITY_KEY_SCANNER_ASSERT_SVH
`define VELOCITY_KEY_SCANNER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VKS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VKS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/vks_pkg.sv
// ----------------------------------------------------------------------------
// vks_pkg
// Shared types and constants of the velocity key scanner.
// ----------------------------------------------------------------------------
package vks_pkg;

    // Default matrix geometry
    localparam int ROWS_DEF         = 8;
    localparam int LOW_COLUMNS_DEF  = 5;
    localparam int HIGH_COLUMNS_DEF = 6;

    // Field widths
    localparam int TIME_W  = 32;
    localparam int KEY_W   = 7;
    localparam int NOTE_W  = 7;
    localparam int VEL_W   = 7;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 2;
    localparam int NUM_W   = 23;
    localparam int QBITS   = 7;

    // Register reset values
    localparam logic [15:0] DEBOUNCE_RST  = 16'd2000;
    localparam logic [15:0] TIMEOUT_RST   = 16'd10000;
    localparam logic [6:0]  LOW_BASE_RST  = 7'd36;
    localparam logic [6:0]  HIGH_BASE_RST = 7'd60;

    // Velocity curve
    localparam logic [15:0] FAST_GAP_US      = 16'd100;
    localparam logic [15:0] MIN_TIMEOUT_US   = 16'd101;
    localparam logic [6:0]  VEL_SPAN         = 7'd126;
    localparam logic [6:0]  DEFAULT_VELOCITY = 7'd64;
    localparam logic [6:0]  MAX_VELOCITY     = 7'd127;
    localparam logic [6:0]  MAX_NOTE         = 7'd127;
    localparam logic [2:0]  DIV_LAST         = 3'd6;

    // Event kinds
    localparam logic EV_NOTE_ON  = 1'b0;
    localparam logic EV_NOTE_OFF = 1'b1;

    typedef enum logic [CIDX_W-1:0] {
        CFG_DEBOUNCE  = 2'd0,
        CFG_TIMEOUT   = 2'd1,
        CFG_LOW_BASE  = 2'd2,
        CFG_HIGH_BASE = 2'd3
    } t_cfg_idx;

    // Per-key record held in the key memory
    typedef struct packed {
        logic [TIME_W-1:0] change;
        logic [TIME_W-1:0] mstamp;
        logic [TIME_W-1:0] bstamp;
        logic              md;
        logic              bd;
        logic              held;
        logic              sent;
        logic              mv;
        logic              bv;
    } t_key_rec;

    typedef struct packed {
        logic accept;
        logic eval;
        logic mul;
        logic div_step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic has_result;
        logic need_div;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

FILE: src/vks_ctrl.sv
// ----------------------------------------------------------------------------
// vks_ctrl
// Sequencer: accept, evaluate, optional multiply and divide, emit if there is a result.
// ----------------------------------------------------------------------------
module vks_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  vks_pkg::t_sts   i_sts,
    output vks_pkg::t_cmd   o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EVAL = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.need_div) begin
                    n_state = S_MUL;
                end else if (i_sts.has_result) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MUL:  n_state = S_DIV;
            S_DIV: begin
                if (i_sts.div_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_s_tready     = (r_state == S_IDLE);
    assign o_cmd.accept   = (r_state == S_IDLE) && i_s_tvalid;
    assign o_cmd.eval     = (r_state == S_EVAL);
    assign o_cmd.mul      = (r_state == S_MUL);
    assign o_cmd.div_step = (r_state == S_DIV);
    assign o_cmd.emit     = (r_state == S_EMIT) && i_sts.out_free;

endmodule

FILE: src/vks_dp.sv
// ----------------------------------------------------------------------------
// vks_dp
// Datapath: config registers, key memory, event logic, velocity divider,
// output register.
// ----------------------------------------------------------------------------
`include "velocity_key_scanner_assert.svh"

module vks_dp #(
    parameter int ROWS         = vks_pkg::ROWS_DEF,
    parameter int LOW_COLUMNS  = vks_pkg::LOW_COLUMNS_DEF,
    parameter int HIGH_COLUMNS = vks_pkg::HIGH_COLUMNS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [vks_pkg::CIDX_W-1:0]  i_cfg_idx,
    input  logic [vks_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic [vks_pkg::KEY_W-1:0]   i_key_index,
    input  logic                        i_make_closed,
    input  logic                        i_break_closed,
    input  logic [vks_pkg::TIME_W-1:0]  i_time_us,
    input  vks_pkg::t_cmd               i_cmd,
    output vks_pkg::t_sts               o_sts,
    input  logic                        i_m_tready,
    output logic                        o_m_tvalid,
    output logic                        o_event_kind,
    output logic [vks_pkg::NOTE_W-1:0]  o_note_number,
    output logic [vks_pkg::VEL_W-1:0]   o_velocity
);

    localparam int LOW_KEYS  = LOW_COLUMNS * ROWS;
    localparam int KEY_COUNT = (LOW_COLUMNS + HIGH_COLUMNS) * ROWS;
    localparam int DEPTH     = (KEY_COUNT < 128) ? KEY_COUNT : 128;
    localparam int IW        = $clog2(DEPTH);

    // Configuration
    logic [15:0] r_debounce;
    logic [15:0] r_timeout;
    logic [6:0]  r_low_base;
    logic [6:0]  r_high_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce  <= vks_pkg::DEBOUNCE_RST;
            r_timeout   <= vks_pkg::TIMEOUT_RST;
            r_low_base  <= vks_pkg::LOW_BASE_RST;
            r_high_base <= vks_pkg::HIGH_BASE_RST;
        end else if (i_cfg_we) begin
            case (vks_pkg::t_cfg_idx'(i_cfg_idx))
                vks_pkg::CFG_DEBOUNCE:  r_debounce  <= i_cfg_data;
                vks_pkg::CFG_TIMEOUT:   r_timeout   <= i_cfg_data;
                vks_pkg::CFG_LOW_BASE:  r_low_base  <= i_cfg_data[6:0];
                vks_pkg::CFG_HIGH_BASE: r_high_base <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Sample capture
    logic [vks_pkg::KEY_W-1:0]  r_key;
    logic                       r_mk;
    logic                       r_br;
    logic [vks_pkg::TIME_W-1:0] r_t;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_key <= i_key_index;
            r_mk  <= i_make_closed;
            r_br  <= i_break_closed;
            r_t   <= i_time_us;
        end
    end

    // Key memory with per-entry valid bits; an unwritten entry reads as zero
    vks_pkg::t_key_rec r_mem [DEPTH];
    vks_pkg::t_key_rec r_rd;
    logic [DEPTH-1:0]  r_vld;
    logic              r_rd_vld;
    vks_pkg::t_key_rec n_rec;
    logic              wr_en;
    logic [IW-1:0]     rd_idx;
    logic [IW-1:0]     wr_idx;

    assign rd_idx = i_key_index[IW-1:0];
    assign wr_idx = r_key[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd <= r_mem[rd_idx];
        end
        if (wr_en) begin
            r_mem[wr_idx] <= n_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_rd_vld <= r_vld[rd_idx];
            end
            if (wr_en) begin
                r_vld[wr_idx] <= 1'b1;
            end
        end
    end

    // Event evaluation
    vks_pkg::t_key_rec          cur;
    logic                       in_range;
    logic                       bounce;
    logic [vks_pkg::TIME_W-1:0] since_change;
    logic [vks_pkg::TIME_W-1:0] mstamp_new;
    logic [vks_pkg::TIME_W-1:0] bstamp_new;
    logic [vks_pkg::TIME_W-1:0] gap;
    logic [vks_pkg::TIME_W-1:0] elapsed;
    logic [15:0]                limit;
    logic                       res;
    logic                       div_path;
    logic                       gap_big;
    logic [6:0]                 imm_vel;
    logic                       ev_kind;
    logic [8:0]                 sec_ofs;
    logic [8:0]                 note_sum;
    logic [6:0]                 note;

    assign cur      = r_rd_vld ? r_rd : '0;
    assign in_range = {3'b0, r_key} < 10'(KEY_COUNT);
    assign limit    = (r_timeout < vks_pkg::MIN_TIMEOUT_US) ?
                      vks_pkg::MIN_TIMEOUT_US : r_timeout;
    assign since_change = r_t - cur.change;
    assign bounce   = since_change < {16'b0, r_debounce};

    // Stamps as they stand after this sample's contact edges
    assign mstamp_new = (r_mk && !cur.md) ? r_t : cur.mstamp;
    assign bstamp_new = (r_br && !cur.bd) ? r_t : cur.bstamp;

    always_comb begin
        n_rec    = cur;
        res      = 1'b0;
        div_path = 1'b0;
        imm_vel  = '0;
        ev_kind  = vks_pkg::EV_NOTE_ON;
        n_rec.md = r_mk;
        n_rec.bd = r_br;
        if ((r_mk != cur.md) || (r_br != cur.bd)) begin
            n_rec.change = r_t;
        end
        if (r_mk && !cur.md) begin
            n_rec.mstamp = r_t;
            n_rec.mv     = 1'b1;
        end
        if (r_br && !cur.bd) begin
            n_rec.bstamp = r_t;
            n_rec.bv     = 1'b1;
        end
        if (!(r_mk || r_br)) begin
            // release: close out the press
            ev_kind = vks_pkg::EV_NOTE_OFF;
            res     = cur.held && cur.sent;
            if (cur.held) begin
                n_rec.held   = 1'b0;
                n_rec.sent   = 1'b0;
                n_rec.mv     = 1'b0;
                n_rec.bv     = 1'b0;
                n_rec.mstamp = '0;
                n_rec.bstamp = '0;
            end
        end else begin
            n_rec.held = 1'b1;
            if (!cur.sent) begin
                if (n_rec.bv && !n_rec.mv) begin
                    res     = 1'b1;
                    imm_vel = vks_pkg::DEFAULT_VELOCITY;
                end else if (n_rec.bv && n_rec.mv) begin
                    res      = 1'b1;
                    div_path = 1'b1;
                    imm_vel  = vks_pkg::DEFAULT_VELOCITY;
                end else if (n_rec.mv && (elapsed > {16'b0, limit})) begin
                    res     = 1'b1;
                    imm_vel = vks_pkg::DEFAULT_VELOCITY;
                end
                n_rec.sent = res;
            end
        end
    end

    assign gap     = bstamp_new - mstamp_new;
    assign elapsed = r_t - mstamp_new;
    assign gap_big = gap > {16'b0, limit};

    assign wr_en = i_cmd.eval && in_range && !bounce;
    assign o_sts.has_result = in_range && !bounce && res;
    assign o_sts.need_div   = in_range && !bounce && res && div_path && !gap_big;

    // Note number of the key, saturated
    always_comb begin
        if ({2'b0, r_key} < 9'(LOW_KEYS)) begin
            sec_ofs  = {2'b0, r_key};
            note_sum = {2'b0, r_low_base} + sec_ofs;
        end else begin
            sec_ofs  = {2'b0, r_key} - 9'(LOW_KEYS);
            note_sum = {2'b0, r_high_base} + sec_ofs;
        end
        note = (note_sum > {2'b0, vks_pkg::MAX_NOTE}) ? vks_pkg::MAX_NOTE : note_sum[6:0];
    end

    // Velocity: 127 - (gap - 100) * 126 / (limit - 100), one quotient bit a step
    logic [15:0]               r_g;
    logic [15:0]               r_den;
    logic [vks_pkg::NUM_W-1:0] r_num;
    logic [vks_pkg::NUM_W-1:0] r_dsh;
    logic [vks_pkg::QBITS-1:0] r_q;
    logic [2:0]                r_cnt;
    logic                      r_kind;
    logic [6:0]                r_note;
    logic [6:0]                r_vel;
    logic                      q_bit;
    logic [6:0]                q_full;

    assign q_bit  = r_num >= r_dsh;
    assign q_full = {r_q[5:0], q_bit};
    assign o_sts.div_last = (r_cnt == vks_pkg::DIV_LAST);

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_kind <= ev_kind;
            r_note <= note;
            r_vel  <= imm_vel;
            r_g    <= (gap[15:0] < vks_pkg::FAST_GAP_US) ? '0 :
                      gap[15:0] - vks_pkg::FAST_GAP_US;
            r_den  <= limit - vks_pkg::FAST_GAP_US;
        end
        if (i_cmd.mul) begin
            r_num <= vks_pkg::NUM_W'(r_g * vks_pkg::VEL_SPAN);
            r_dsh <= {1'b0, r_den, 6'b0};
            r_q   <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            if (q_bit) begin
                r_num <= r_num - r_dsh;
            end
            r_dsh <= r_dsh >> 1;
            r_q   <= q_full;
            r_cnt <= r_cnt + 3'd1;
            if (r_cnt == vks_pkg::DIV_LAST) begin
                r_vel <= vks_pkg::MAX_VELOCITY - q_full;
            end
        end
    end

    // Output register
    logic       r_out_vld;
    logic       r_out_kind;
    logic [6:0] r_out_note;
    logic [6:0] r_out_vel;

    assign o_sts.out_free = !r_out_vld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_kind <= r_kind;
            r_out_note <= r_note;
            r_out_vel  <= r_vel;
        end
    end

    assign o_m_tvalid    = r_out_vld;
    assign o_event_kind  = r_out_kind;
    assign o_note_number = r_out_note;
    assign o_velocity    = r_out_vel;

    `VKS_ASSERT_SAME(a_emit_free, i_clk, i_rst_n, i_cmd.emit, !r_out_vld || i_m_tready, "emit over pending result")
    `VKS_ASSERT_SAME(a_eval_after_read, i_clk, i_rst_n, i_cmd.eval, $past(i_cmd.accept), "evaluate without read")
    `VKS_ASSERT_NEXT(a_div_vel, i_clk, i_rst_n, i_cmd.div_step && (r_cnt == vks_pkg::DIV_LAST), r_vel != 7'd0, "zero strike velocity")

endmodule

FILE: src/velocity_key_scanner.sv
// ----------------------------------------------------------------------------
// velocity_key_scanner
// Dual-contact keyboard scanner giving note-on with strike velocity and
// note-off per key, from per-key scan samples.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata (low bit up)                     | tuser
//  s (scan) | in        | key_index 7, make 1, break 1, time 32, | -
//           |           | zero pad to 48                          |
//  m (note) | out       | note_number 7, velocity 7, pad to 16    | event_kind
//  cfg      | in        | i_cfg_we / i_cfg_idx / i_cfg_data[15:0] | -
//
//  Each item is accepted, then evaluated with its key record written back;
//  an item with no result then returns to idle, a note-off or a
//  default-velocity note-on adds an emit step, and a timed note-on adds a
//  multiply and 7 steps of the restoring divider before the emit. A new
//  item is accepted only in idle. A result is valid the cycle after its emit
//  cycle. Reset is synchronous and clears the controller, config registers,
//  output valid and the per-key valid bits; no clearing pass is needed.
//  A held result stalls the next result's emit, and with it all new items.
// ----------------------------------------------------------------------------
module velocity_key_scanner #(
    parameter int ROWS         = vks_pkg::ROWS_DEF,
    parameter int LOW_COLUMNS  = vks_pkg::LOW_COLUMNS_DEF,
    parameter int HIGH_COLUMNS = vks_pkg::HIGH_COLUMNS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration write
    input  logic                        i_cfg_we,
    input  logic [vks_pkg::CIDX_W-1:0]  i_cfg_idx,
    input  logic [vks_pkg::CFG_W-1:0]   i_cfg_data,
    // scan samples
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [47:0]                 i_s_tdata,  // key_index, make, break, time_us
    // note events
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [15:0]                 o_m_tdata,  // note_number, velocity
    output logic                        o_m_tuser   // event_kind
);

    vks_pkg::t_cmd cmd;
    vks_pkg::t_sts sts;
    logic [6:0]    note_number;
    logic [6:0]    velocity;

    // Sequence each item through the datapath
    vks_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Unpack the sample and hold per-key state
    vks_dp #(
        .ROWS         (ROWS),
        .LOW_COLUMNS  (LOW_COLUMNS),
        .HIGH_COLUMNS (HIGH_COLUMNS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_key_index    (i_s_tdata[6:0]),
        .i_make_closed  (i_s_tdata[7]),
        .i_break_closed (i_s_tdata[8]),
        .i_time_us      (i_s_tdata[40:9]),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_m_tready     (i_m_tready),
        .o_m_tvalid     (o_m_tvalid),
        .o_event_kind   (o_m_tuser),
        .o_note_number  (note_number),
        .o_velocity     (velocity)
    );

    // Pack the result with zero fill
    assign o_m_tdata = {2'b00, velocity, note_number};

endmodule
